FILE: hw/rtl/dmlp_pkg.sv
`timescale 1ns / 1ps

package dmlp_pkg;

  // Field widths.
  localparam int unsigned LightW   = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned LedW     = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Register reset values.
  localparam logic [LightW-1:0] LightThresholdRst = 10'd100;
  localparam logic [CountW-1:0] DebounceMsRst     = 16'd50;
  localparam logic [CountW-1:0] BlinkPeriodMsRst  = 16'd1000;

  // Saturation value of the elapsed counters.
  localparam logic [CountW-1:0] CountMax = '1;

  // LED patterns.
  localparam logic [LedW-1:0] LedAllOff = 4'h0;
  localparam logic [LedW-1:0] LedAllOn  = 4'hF;
  localparam logic [LedW-1:0] LedAltOdd = 4'h5;
  localparam logic [LedW-1:0] LedAltEvn = 4'hA;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_THRESHOLD = 2'd0,
    CFG_DEBOUNCE_MS     = 2'd1,
    CFG_BLINK_PERIOD_MS = 2'd2
  } cfg_idx_t;

  // Operating modes.
  typedef enum logic [ModeW-1:0] {
    MODE_STEADY = 2'd0,
    MODE_ALT    = 2'd1,
    MODE_BLINK  = 2'd2
  } mode_t;

endpackage

FILE: hw/rtl/debounced_mode_led_pattern_controller_unit.sv
`timescale 1ns / 1ps

// Debounced mode LED pattern controller.
// The input stream carries one millisecond tick per transaction: the raw
// button level and a ten-bit light sample. Every tick yields one result
// transaction with the latched LED pattern and the current mode.
// The button is debounced by a saturating tick counter; each new stable
// press steps the mode 0, 1, 2, 1, 2 and restarts the blink timer.
// The configuration channel writes the light threshold, the debounce length
// and the blink period; it is always ready and should be used while idle.
// A tick is captured in the input register, then the state update and result
// register are written once the result stage can advance. Throughput is one
// tick per cycle while the receiver does not stall.
// Reset clears both channels, all counters, the mode and the LEDs, and loads
// the register defaults. When the receiver stalls, the result is held and
// one more tick is taken into the input register; then in_tready drops.
module debounced_mode_led_pattern_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream. tdata: [0] button_level, [10:1] light_sample, rest zero.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dmlp_pkg::InDataW-1:0]    in_tdata,
  // Result stream. tdata: [3:0] led_pattern, [5:4] mode_now, rest zero.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dmlp_pkg::OutDataW-1:0]   out_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmlp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dmlp_pkg::CfgDataW-1:0]   cfg_data
);

  import dmlp_pkg::*;

  // Configuration registers.
  logic [LightW-1:0] light_threshold_r;
  logic [CountW-1:0] debounce_ms_r;
  logic [CountW-1:0] blink_period_ms_r;

  // Input stage.
  logic              s1_valid_r;
  logic              s1_button_r;
  logic [LightW-1:0] s1_light_r;

  // Controller state.
  logic              prev_raw_r;
  logic              stable_button_r;
  logic [CountW-1:0] debounce_elapsed_r;
  mode_t             mode_r;
  logic              alt_phase_r;
  logic              blink_phase_r;
  logic [CountW-1:0] blink_elapsed_r;
  logic [LedW-1:0]   led_latch_r;

  // Result stage.
  logic              out_valid_r;

  // Next values.
  logic              stable_button_nxt;
  logic [CountW-1:0] debounce_elapsed_nxt;
  mode_t             mode_nxt;
  logic              alt_phase_nxt;
  logic              blink_phase_nxt;
  logic [CountW-1:0] blink_elapsed_nxt;
  logic [LedW-1:0]   led_latch_nxt;
  logic              press;

  // Handshake control.
  logic              advance;
  logic              s2_fire;
  logic              in_fire;
  logic              cfg_fire;

  assign advance   = !out_valid_r || out_tready;
  assign s2_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_threshold_r <= LightThresholdRst;
      debounce_ms_r     <= DebounceMsRst;
      blink_period_ms_r <= BlinkPeriodMsRst;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_LIGHT_THRESHOLD: light_threshold_r <= cfg_data[LightW-1:0];
        CFG_DEBOUNCE_MS:     debounce_ms_r     <= cfg_data[CountW-1:0];
        CFG_BLINK_PERIOD_MS: blink_period_ms_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_button_r <= in_tdata[0];
      s1_light_r  <= in_tdata[LightW:1];
    end
  end

  // Debounce, mode step and LED pattern for one tick.
  always_comb begin
    logic [CountW-1:0] deb_inc;
    logic [CountW-1:0] blink_inc;
    logic              rise;

    deb_inc   = (debounce_elapsed_r == CountMax) ? CountMax : debounce_elapsed_r + 1'b1;
    blink_inc = (blink_elapsed_r == CountMax) ? CountMax : blink_elapsed_r + 1'b1;

    // A change of the raw level restarts the debounce timer.
    debounce_elapsed_nxt = (s1_button_r != prev_raw_r) ? '0 : deb_inc;
    rise = (debounce_elapsed_nxt > debounce_ms_r) && (s1_button_r != stable_button_r);
    stable_button_nxt = rise ? s1_button_r : stable_button_r;
    press = rise && s1_button_r;

    // A new press steps the mode, clears the LEDs and the blink timer.
    mode_nxt          = mode_r;
    led_latch_nxt     = led_latch_r;
    blink_elapsed_nxt = blink_inc;
    if (press) begin
      unique case (mode_r)
        MODE_STEADY: mode_nxt = MODE_ALT;
        MODE_ALT:    mode_nxt = MODE_BLINK;
        default:     mode_nxt = MODE_ALT;
      endcase
      led_latch_nxt     = LedAllOff;
      blink_elapsed_nxt = '0;
    end

    // LED pattern, only while it is dark.
    alt_phase_nxt   = alt_phase_r;
    blink_phase_nxt = blink_phase_r;
    if (s1_light_r < light_threshold_r) begin
      unique case (mode_nxt)
        MODE_ALT: begin
          if (blink_elapsed_nxt > blink_period_ms_r) begin
            led_latch_nxt     = alt_phase_r ? LedAltOdd : LedAltEvn;
            alt_phase_nxt     = !alt_phase_r;
            blink_elapsed_nxt = '0;
          end
        end
        MODE_BLINK: begin
          if (blink_elapsed_nxt > blink_period_ms_r) begin
            led_latch_nxt     = blink_phase_r ? LedAllOn : LedAllOff;
            blink_phase_nxt   = !blink_phase_r;
            blink_elapsed_nxt = '0;
          end
        end
        default: led_latch_nxt = LedAllOn;
      endcase
    end else begin
      led_latch_nxt = LedAllOff;
    end
  end

  // State update, once per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r         <= 1'b0;
      stable_button_r    <= 1'b0;
      debounce_elapsed_r <= '0;
      mode_r             <= MODE_STEADY;
      alt_phase_r        <= 1'b0;
      blink_phase_r      <= 1'b0;
      blink_elapsed_r    <= '0;
      led_latch_r        <= LedAllOff;
    end else if (s2_fire) begin
      prev_raw_r         <= s1_button_r;
      stable_button_r    <= stable_button_nxt;
      debounce_elapsed_r <= debounce_elapsed_nxt;
      mode_r             <= mode_nxt;
      alt_phase_r        <= alt_phase_nxt;
      blink_phase_r      <= blink_phase_nxt;
      blink_elapsed_r    <= blink_elapsed_nxt;
      led_latch_r        <= led_latch_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - ModeW - LedW){1'b0}}, mode_r, led_latch_r};

`ifndef ASSERT_OFF
  // The mode moves only when a tick is processed.
  a_mode_held: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_fire |=> $stable(mode_r))
    else $error("mode changed without a processed tick");

  // After a press the LEDs are dark and the blink timer is restarted.
  a_press_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && press |=> led_latch_r == LedAllOff && blink_elapsed_r == '0)
    else $error("press did not clear LEDs and blink timer");

  // Input is refused only when both stages are full and the output stalls.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input refused with room in the pipeline");

  // A result appears only from a tick held in the input register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a registered tick");
`endif

endmodule

FILE: tb/sv/tb_debounced_mode_led_pattern_controller_unit.sv
`timescale 1ns / 1ps

module tb_debounced_mode_led_pattern_controller_unit;
  import dmlp_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleTicks = 6;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PhaseTicks  = 230;
  localparam int unsigned PhaseCount  = 7;
  localparam int unsigned LightMax    = 1023;
  localparam int unsigned SatTicks    = 40;

  // Index past the register list; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [LedW-1:0] leds;
    mode_t           mode;
  } tick_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // Shadow of the controller: registers and tick state.
  logic [LightW-1:0] thr_q;
  logic [CountW-1:0] debounce_q;
  logic [CountW-1:0] period_q;
  logic              raw_prev;
  logic              btn_stable;
  logic [CountW-1:0] debounce_cnt;
  logic [CountW-1:0] blink_cnt;
  mode_t             mode_q;
  logic              alt_ph;
  logic              blink_ph;
  logic [LedW-1:0]   leds_q;

  tick_result_t pending_results[$];
  int unsigned  mismatch_cnt   = 0;
  int unsigned  idle_cycles    = 0;
  int unsigned  out_stall_left = 0;
  bit           in_gaps_on     = 1'b0;
  bit           out_stalls_on  = 1'b0;

  debounced_mode_led_pattern_controller_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(ClkHalf) clk = ~clk;

  function automatic void reset_controller_model();
    thr_q        = LightThresholdRst;
    debounce_q   = DebounceMsRst;
    period_q     = BlinkPeriodMsRst;
    raw_prev     = 1'b0;
    btn_stable   = 1'b0;
    debounce_cnt = '0;
    blink_cnt    = '0;
    mode_q       = MODE_STEADY;
    alt_ph       = 1'b0;
    blink_ph     = 1'b0;
    leds_q       = LedAllOff;
  endfunction

  function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    unique case (idx)
      CFG_LIGHT_THRESHOLD: thr_q = data[LightW-1:0];
      CFG_DEBOUNCE_MS:     debounce_q = data[CountW-1:0];
      CFG_BLINK_PERIOD_MS: period_q = data[CountW-1:0];
      default: ;
    endcase
  endfunction

  // One millisecond tick: debounce, mode stepping, then the LED pattern.
  function automatic tick_result_t advance_tick(logic raw, logic [LightW-1:0] light);
    tick_result_t res;
    debounce_cnt = (debounce_cnt == CountMax) ? debounce_cnt : debounce_cnt + 1'b1;
    blink_cnt    = (blink_cnt == CountMax) ? blink_cnt : blink_cnt + 1'b1;
    if (raw != raw_prev) debounce_cnt = '0;
    if (debounce_cnt > debounce_q && raw != btn_stable) begin
      btn_stable = raw;
      if (raw) begin
        // Steady and blink both step to alternating; alternating steps to blink.
        mode_q    = (mode_q == MODE_ALT) ? MODE_BLINK : MODE_ALT;
        leds_q    = LedAllOff;
        blink_cnt = '0;
      end
    end
    raw_prev = raw;
    if (light < thr_q) begin
      unique case (mode_q)
        MODE_ALT: begin
          if (blink_cnt > period_q) begin
            leds_q    = alt_ph ? LedAltOdd : LedAltEvn;
            alt_ph    = !alt_ph;
            blink_cnt = '0;
          end
        end
        MODE_BLINK: begin
          if (blink_cnt > period_q) begin
            leds_q    = blink_ph ? LedAllOn : LedAllOff;
            blink_ph  = !blink_ph;
            blink_cnt = '0;
          end
        end
        default: leds_q = LedAllOn;
      endcase
    end else begin
      leds_q = LedAllOff;
    end
    res.leds = leds_q;
    res.mode = mode_q;
    return res;
  endfunction

  // Track every accepted register write and tick in the shadow model.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        pending_results.push_back(advance_tick(in_tdata[0], in_tdata[LightW:1]));
      end
    end
  end

  // Compare each result transaction with the oldest expected tick result.
  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.leds = out_tdata[LedW-1:0];
      got.mode = mode_t'(out_tdata[LedW+ModeW-1:LedW]);
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < ReportMax) begin
          $display("unexpected result: leds=%h mode=%0d", got.leds, got.mode);
        end
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.leds != want.leds || got.mode != want.mode) begin
          if (mismatch_cnt < ReportMax) begin
            $display("mismatch at %0t: expected leds=%h mode=%0d, actual leds=%h mode=%0d",
                     $realtime, want.leds, want.mode, got.leds, got.mode);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Result receiver: random stalls, mostly short, a few long.
  always @(posedge clk) begin
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!out_stalls_on) begin
      out_tready <= 1'b1;
    end else if (out_stall_left != 0) begin
      out_tready     <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (roll < 65) begin
      out_tready <= 1'b1;
    end else if (roll < 95) begin
      out_tready     <= 1'b0;
      out_stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready     <= 1'b0;
      out_stall_left <= $urandom_range(10, 60);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_debounced_mode_led_pattern_controller_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!in_gaps_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Light samples cluster around the threshold and the range ends; many lie below the threshold.
  function automatic logic [LightW-1:0] pick_light();
    int unsigned roll;
    int          near_val;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 15) return LightW'(LightMax);
    if (roll < 35) begin
      near_val = int'(thr_q) + int'($urandom_range(0, 2)) - 1;
      if (near_val < 0) near_val = 0;
      if (near_val > int'(LightMax)) near_val = int'(LightMax);
      return LightW'(near_val);
    end
    if (roll < 80 && thr_q != 0) return LightW'($urandom_range(0, int'(thr_q) - 1));
    return LightW'($urandom_range(0, LightMax));
  endfunction

  // Valid stays high between back-to-back ticks and only drops for a gap.
  task automatic send_tick(input logic raw, input logic [LightW-1:0] light);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InDataW'({light, raw});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_button(input logic raw, input int unsigned ticks,
                             input logic [LightW-1:0] light);
    repeat (ticks) send_tick(raw, light);
  endtask

  task automatic hold_button_random_light(input logic raw, input int unsigned ticks);
    repeat (ticks) send_tick(raw, pick_light());
  endtask

  // Stop sending and wait until every expected tick result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] deb,
                           input logic [CfgDataW-1:0] period);
    write_reg(CFG_LIGHT_THRESHOLD, thr, 1'b0);
    write_reg(CFG_DEBOUNCE_MS, deb, 1'b0);
    write_reg(CFG_BLINK_PERIOD_MS, period, 1'b1);
  endtask

  // Reset values: light just under and at the default threshold, short bounces.
  task automatic test_default_registers();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_tick(1'b0, 10'd0);
    send_tick(1'b1, 10'd99);
    send_tick(1'b1, 10'd100);
    send_tick(1'b0, 10'd1023);
    send_tick(1'b1, 10'd0);
    send_tick(1'b0, 10'd512);
    drain_results();
  endtask

  // Presses walk the modes steady, alternating, blink, alternating.
  task automatic test_mode_sequence();
    // The spare index must not disturb anything; the threshold write drops upper bits.
    write_reg(CfgIdxSpare, 16'hFFFF, 1'b0);
    configure(16'hFFFF, 16'd0, 16'd1);
    hold_button(1'b1, 2, 10'd0);
    hold_button(1'b1, 3, 10'd0);
    hold_button(1'b0, 2, 10'd0);
    hold_button(1'b1, 2, 10'd0);
    hold_button(1'b1, 3, 10'd1022);
    // Bright light forces the LEDs off.
    hold_button(1'b1, 1, 10'd1023);
    hold_button(1'b0, 2, 10'd0);
    hold_button(1'b1, 2, 10'd0);
    drain_results();
  endtask

  // Limits at the top of the counter range are not passed in a short run.
  task automatic test_counter_saturation();
    in_gaps_on = 1'b0;
    configure(16'(LightMax), 16'hFFFF, 16'hFFFF);
    hold_button(1'b0, SatTicks, 10'd0);
    drain_results();
    configure(16'(LightMax), 16'hFFFE, 16'hFFFE);
    hold_button(1'b0, 3, 10'd0);
    drain_results();
    in_gaps_on = 1'b1;
  endtask

  // Mostly clean press and release runs, with bounces and single-tick noise.
  task automatic test_random_phases();
    int unsigned sent;
    int unsigned deb;
    int unsigned roll;
    int unsigned len;
    logic        level;
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      in_gaps_on    = (phase != 4);
      out_stalls_on = (phase != 4);
      unique case (phase)
        0:       configure(16'(LightMax), 16'd0, 16'd0);
        1:       configure(16'd0, 16'd2, 16'd3);
        2:       configure(16'd512, 16'd20, 16'd40);
        5:       configure(16'($urandom_range(0, LightMax)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 30)));
        default: configure(16'($urandom_range(0, LightMax)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 10)));
      endcase
      deb   = debounce_q;
      level = btn_stable;
      sent  = 0;
      while (sent < PhaseTicks) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          level = !level;
          len   = $urandom_range(deb + 1, deb + 6);
        end else if (roll < 90) begin
          level = !level;
          len   = $urandom_range(1, deb + 1);
        end else begin
          level = 1'($urandom_range(0, 1));
          len   = 1;
        end
        hold_button_random_light(level, len);
        sent += len;
      end
      drain_results();
    end
  endtask

  initial begin
    reset_controller_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_mode_sequence();
    test_counter_saturation();
    test_random_phases();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_debounced_mode_led_pattern_controller_unit: clean");
    end else begin
      $display("tb_debounced_mode_led_pattern_controller_unit: errors");
    end
    $finish;
  end

endmodule
